// ----- src/cbrd_pkg.sv -----
// Shared constants, codes and bank selection helpers of the cartridge bank register decoder.
`default_nettype none

package cbrd_pkg;

  // bank geometry
  localparam int unsigned BANK_SHIFT = 13;
  localparam int unsigned BANK_W     = 6;
  localparam int unsigned FADDR_W    = 19;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXTERNAL_ENABLE = 2'd0,
    CFG_PRIMARY_ENABLE  = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    FUNC_REG_RD = 2'd0,
    FUNC_REG_WR = 2'd1,
    FUNC_WIN_RD = 2'd2,
    FUNC_WIN_WR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DRV_NONE = 2'd0,
    DRV_RD   = 2'd1,
    DRV_WR   = 2'd2
  } drive_access_t;

  typedef enum logic [1:0] {
    FLASH_NONE = 2'd0,
    FLASH_RD   = 2'd1,
    FLASH_WR   = 2'd2
  } flash_access_t;

  // I/O page and register offsets
  localparam logic [7:0] IO_PAGE        = 8'hD5;
  localparam logic [7:0] OFF_FIRST      = 8'hE0;
  localparam logic [7:0] OFF_PRIMARY    = 8'hE0;
  localparam logic [7:0] OFF_CLOCK      = 8'hE2;
  localparam logic [7:0] OFF_TOP        = 8'hE4;
  localparam logic [7:0] OFF_DRIVE_LO   = 8'hF0;
  localparam logic [7:0] OFF_DRIVE_HI   = 8'hF7;
  localparam logic [7:0] OFF_DRST_LO    = 8'hF8;
  localparam logic [7:0] OFF_DRST_HI    = 8'hFB;
  localparam logic [7:0] OFF_ID0        = 8'hFC;
  localparam logic [7:0] OFF_ID1        = 8'hFD;
  localparam logic [7:0] OFF_ID2        = 8'hFE;
  localparam logic [7:0] OFF_ID3        = 8'hFF;

  // read values
  localparam logic [7:0] RD_OPEN        = 8'hFF;
  localparam logic [7:0] RD_CLOCK_BIT   = 8'h08;
  localparam logic [7:0] RD_ID0_ON      = 8'h53;
  localparam logic [7:0] RD_ID0_OFF     = 8'h20;
  localparam logic [7:0] RD_ID1         = 8'h49;
  localparam logic [7:0] RD_ID2         = 8'h44;
  localparam logic [7:0] RD_ID3         = 8'h45;

  // window
  localparam logic [15:0] WIN_BASE      = 16'hA000;
  localparam logic [15:0] WIN_LAST      = 16'hBFFF;

  // top bank is stored with bit 5 flipped
  localparam logic [BANK_W-1:0] TOP_BANK_FLIP  = 6'h20;
  localparam logic [BANK_W-1:0] TOP_BANK_RESET = 6'h20;

  typedef struct packed {
    logic              primary_off;
    logic [BANK_W-1:0] primary_bank;
    logic              top_enable;
    logic              top_off;
    logic [BANK_W-1:0] top_bank;
  } bank_regs_t;

  function automatic logic primary_valid(input bank_regs_t b, input logic primary_en);
    primary_valid = primary_en && !b.primary_off;
  endfunction

  function automatic logic top_valid(input bank_regs_t b, input logic primary_en);
    top_valid = !b.top_off && (b.top_enable || !primary_en);
  endfunction

  function automatic logic bank_valid(input bank_regs_t b, input logic primary_en);
    bank_valid = primary_valid(b, primary_en) || top_valid(b, primary_en);
  endfunction

  // no valid bank: last bank is held
  function automatic logic [BANK_W-1:0] select_bank(input bank_regs_t b,
                                                    input logic primary_en,
                                                    input logic [BANK_W-1:0] cur);
    if (primary_valid(b, primary_en)) begin
      select_bank = b.primary_bank;
    end else if (top_valid(b, primary_en)) begin
      select_bank = b.top_bank;
    end else begin
      select_bank = cur;
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/cartridge_bank_register_decoder.sv -----
// Top level: I/O page decode, bank registers and flash window address generation.
//
// Each bus access arrives as one input transaction and yields exactly one result
// transaction. Decode, bank register update and flash address generation are a
// single pass of shallow logic into the result register, so one access is taken
// every clock cycle; the only limit is the result register, which accepts a new
// access whenever it is empty or being drained in the same cycle. Bank writes at
// offsets E0/E4 take effect for the very next access. The user must write the two
// configuration bits on the cfg port (always ready) only while the block is idle;
// the block itself does not enforce it. Writes to unknown indexes are ignored.
`default_nettype none

module cartridge_bank_register_decoder
  import cbrd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [15:0] address, [23:16] write_data, [31:24] drive_data, [32] clock_bit,
  // [33] flash_command_mode, [39:34] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] func
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,

  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [7:0] read_data, [8] claimed, [10:9] drive_access, [13:11] drive_register,
  // [14] drive_reset_update, [15] drive_reset_level, [16] clock_update,
  // [19:17] clock_pins, [38:20] flash_address, [40:39] flash_access,
  // [41] window_enable, [42] control_read_route, [47:43] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,

  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  func_t       func;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [7:0]  drive_data;
  logic        clock_bit;
  logic        flash_command_mode;

  assign func               = func_t'(in_tuser[1:0]);
  assign address            = in_tdata[15:0];
  assign write_data         = in_tdata[23:16];
  assign drive_data         = in_tdata[31:24];
  assign clock_bit          = in_tdata[32];
  assign flash_command_mode = in_tdata[33];

  logic              ext_en_r, ext_en_nxt;
  logic              pri_en_r, pri_en_nxt;
  bank_regs_t        banks_r, banks_nxt;
  logic [BANK_W-1:0] cur_bank_r, cur_bank_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic in_acc, cfg_acc;
  assign in_tready = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // result fields
  logic [7:0]         read_data;
  logic               claimed;
  drive_access_t      drive_access;
  logic [2:0]         drive_register;
  logic               drive_reset_update;
  logic               drive_reset_level;
  logic               clock_update;
  logic [2:0]         clock_pins;
  logic [FADDR_W-1:0] flash_address;
  flash_access_t      flash_access;
  logic               window_enable;
  logic               control_read_route;

  logic [7:0]         off;
  bank_regs_t         banks_upd;
  logic [BANK_W-1:0]  bank_upd;
  logic               in_window;
  logic [15:0]        win_off;

  assign off = address[7:0];

  always_comb begin
    read_data          = '0;
    claimed            = 1'b0;
    drive_access       = DRV_NONE;
    drive_register     = '0;
    drive_reset_update = 1'b0;
    drive_reset_level  = 1'b0;
    clock_update       = 1'b0;
    clock_pins         = '0;
    banks_upd          = banks_r;

    if ((func == FUNC_REG_RD || func == FUNC_REG_WR) &&
        address[15:8] == IO_PAGE && off >= OFF_FIRST) begin
      claimed = 1'b1;
      if (func == FUNC_REG_RD) begin
        case (off) inside
          OFF_CLOCK: read_data = clock_bit ? RD_CLOCK_BIT : 8'h00;
          [OFF_DRIVE_LO:OFF_DRIVE_HI]: begin
            read_data      = drive_data;
            drive_access   = DRV_RD;
            drive_register = off[2:0];
          end
          OFF_ID0: read_data = pri_en_r ? RD_ID0_ON : RD_ID0_OFF;
          OFF_ID1: read_data = RD_ID1;
          OFF_ID2: read_data = RD_ID2;
          OFF_ID3: read_data = RD_ID3;
          default: read_data = RD_OPEN;
        endcase
      end else begin
        case (off) inside
          OFF_PRIMARY: begin
            banks_upd.primary_off  = write_data[7];
            banks_upd.primary_bank = write_data[BANK_W-1:0];
            banks_upd.top_enable   = !write_data[6];
          end
          OFF_CLOCK: begin
            clock_update = 1'b1;
            clock_pins   = {write_data[2], !write_data[1], write_data[0]};
          end
          OFF_TOP: begin
            banks_upd.top_off  = write_data[7];
            banks_upd.top_bank = write_data[BANK_W-1:0] ^ TOP_BANK_FLIP;
          end
          [OFF_DRIVE_LO:OFF_DRIVE_HI]: begin
            drive_access   = DRV_WR;
            drive_register = off[2:0];
          end
          [OFF_DRST_LO:OFF_DRST_HI]: begin
            drive_reset_update = 1'b1;
            drive_reset_level  = !write_data[0];
          end
          default: ;
        endcase
      end
    end

    bank_upd           = select_bank(banks_upd, pri_en_r, cur_bank_r);
    window_enable      = bank_valid(banks_upd, pri_en_r) && ext_en_r;
    control_read_route = window_enable && flash_command_mode;

    in_window     = address >= WIN_BASE && address <= WIN_LAST;
    win_off       = address - WIN_BASE;
    flash_access  = FLASH_NONE;
    flash_address = '0;
    if ((func == FUNC_WIN_RD || func == FUNC_WIN_WR) && in_window && window_enable) begin
      flash_access  = (func == FUNC_WIN_RD) ? FLASH_RD : FLASH_WR;
      flash_address = FADDR_W'(32'(bank_upd) << BANK_SHIFT) + FADDR_W'(win_off);
    end
  end

  // config writes re-run bank selection with the new enables
  logic cfg_val;
  assign cfg_val = cfg_data[0];

  always_comb begin
    ext_en_nxt    = ext_en_r;
    pri_en_nxt    = pri_en_r;
    banks_nxt     = banks_r;
    cur_bank_nxt  = cur_bank_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_acc) begin
      case (cfg_index)
        CFG_EXTERNAL_ENABLE: begin
          ext_en_nxt   = cfg_val;
          cur_bank_nxt = select_bank(banks_r, pri_en_r, cur_bank_r);
        end
        CFG_PRIMARY_ENABLE: begin
          pri_en_nxt   = cfg_val;
          cur_bank_nxt = select_bank(banks_r, cfg_val, cur_bank_r);
        end
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      banks_nxt     = banks_upd;
      cur_bank_nxt  = bank_upd;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {5'b0, control_read_route, window_enable, flash_access,
                       flash_address, clock_pins, clock_update, drive_reset_level,
                       drive_reset_update, drive_register, drive_access, claimed,
                       read_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_en_r    <= 1'b1;
      pri_en_r    <= 1'b1;
      banks_r     <= '{primary_off: 1'b0, primary_bank: '0, top_enable: 1'b0,
                       top_off: 1'b0, top_bank: TOP_BANK_RESET};
      cur_bank_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ext_en_r    <= ext_en_nxt;
      pri_en_r    <= pri_en_nxt;
      banks_r     <= banks_nxt;
      cur_bank_r  <= cur_bank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
